@@ rtl/srr_pkg.sv @@
// Shared types and constants for the segmented response reassembler.
// No dependencies; used by every module of the block.
package srr_pkg;

  localparam int unsigned NumLanes  = 7;  // payload byte positions byte1..byte7
  localparam int unsigned NumSlots  = NumLanes + 1;
  localparam int unsigned FcSlot    = NumLanes;  // flow-control slot follows the lanes
  localparam int unsigned FirstLane = 4;  // first frame carries payload in byte5..byte7

  localparam int unsigned IdxW = 12;
  localparam int unsigned SelW = $clog2(NumSlots);

  localparam logic [7:0]      PciMask      = 8'hF0;
  localparam logic [3:0]      LowNibble    = 4'h0F;
  localparam logic [3:0]      PciFirst     = 4'h1;
  localparam logic [3:0]      PciConsec    = 4'h2;
  localparam logic [7:0]      PositiveCode = 8'h62;
  localparam logic [IdxW-1:0] HeaderBytes  = 12'd3;

  localparam logic KindPayload = 1'b0;
  localparam logic KindFlowCtl = 1'b1;

  typedef struct packed {
    logic            valid;
    logic [7:0]      data;
    logic [IdxW-1:0] index;
    logic            done;
  } lane_res_t;

endpackage

@@ rtl/srr_lane.sv @@
// One payload byte lane: checks its index against the message length.
// Depends on srr_pkg.
module srr_lane (
  input  logic                         en_i,
  input  logic [7:0]                   data_i,
  input  logic [srr_pkg::IdxW:0]       index_i,
  input  logic [srr_pkg::IdxW-1:0]     plen_i,
  output srr_pkg::lane_res_t           res_o
);

  logic [srr_pkg::IdxW:0] plen_ext;

  always_comb begin
    plen_ext    = {1'b0, plen_i};
    res_o.valid = en_i && (index_i < plen_ext);
    res_o.data  = data_i;
    res_o.index = index_i[srr_pkg::IdxW-1:0];
    res_o.done  = (index_i + 13'd1) == plen_ext;
  end

endmodule

@@ rtl/srr_merge.sv @@
// Result merge: captures the lane results of one frame plus the
// flow-control slot and, while out_stall_i is low, hands them out one
// per cycle in lane order. Depends on srr_pkg.
module srr_merge (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  srr_pkg::lane_res_t [srr_pkg::NumLanes-1:0] lanes_i,
  input  logic                                      fc_valid_i,
  input  logic [7:0]                                fc_data_i,
  input  logic [15:0]                               ident_i,
  output logic                                      ready_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      kind_o,
  output logic [7:0]                                data_byte_o,
  output logic [srr_pkg::IdxW-1:0]                  byte_index_o,
  output logic [15:0]                               data_ident_o,
  output logic                                      last_of_run_o,
  output logic                                      message_done_o
);

  logic [srr_pkg::NumSlots-1:0] mask_q, mask_d;
  logic [srr_pkg::NumSlots-1:0] low, rest, mask_after, new_mask;
  srr_pkg::lane_res_t [srr_pkg::NumSlots-1:0] slot_q;
  logic [15:0] ident_q;
  logic        pop;
  srr_pkg::lane_res_t cur;

  always_comb begin
    low        = mask_q & (~mask_q + 8'd1);
    rest       = mask_q & ~low;
    pop        = out_valid_o && !out_stall_i;
    mask_after = pop ? rest : mask_q;
    ready_o    = (mask_after == '0);
    for (int k = 0; k < srr_pkg::NumLanes; k++) begin
      new_mask[k] = lanes_i[k].valid;
    end
    new_mask[srr_pkg::FcSlot] = fc_valid_i;
    mask_d = load_i ? new_mask : mask_after;

    cur = '0;
    for (int k = 0; k < srr_pkg::NumSlots; k++) begin
      if (low[k]) begin
        cur = cur | slot_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < srr_pkg::NumLanes; k++) begin
        slot_q[k] <= lanes_i[k];
      end
      slot_q[srr_pkg::FcSlot] <= '{valid: fc_valid_i, data: fc_data_i,
                                   index: '0, done: 1'b0};
      ident_q <= ident_i;
    end
  end

  // flow-control slot is the only one with kind set
  assign out_valid_o    = (mask_q != '0);
  assign kind_o         = low[srr_pkg::FcSlot] ? srr_pkg::KindFlowCtl
                                               : srr_pkg::KindPayload;
  assign data_byte_o    = cur.data;
  assign byte_index_o   = cur.index;
  assign data_ident_o   = ident_q;
  assign last_of_run_o  = (rest == '0);
  assign message_done_o = cur.done;

endmodule

@@ rtl/segmented_response_reassembler_core.sv @@
// Segmented response reassembler (multi-frame receive of a diagnostic reply).
// Input: one 8-byte frame per request on byte0_i..byte7_i with in_valid_i /
// in_stall_o. Output: one result per request (payload byte or flow-control
// request) with out_valid_o / out_stall_i. Register write: cfg_we_i with
// cfg_wdata_i sets the separation time placed in flow-control requests.
// A frame is decoded and the message state updated in the cycle it is
// accepted; seven byte lanes check their positions in parallel and the
// merge stage captures the frame's results. They appear from the next cycle
// on, one per cycle while out_stall_i is low; a first frame yields up to 4,
// counting its flow-control request, and a consecutive frame up to 7.
// A new frame is taken in the cycle the last result of the previous one is
// taken; a frame with no results does not hold up the next frame. While
// out_stall_i is high the current result holds and in_stall_o stays high
// once the merge stage has results left. Reset (rst_ni low, asynchronous)
// makes the block idle, clears message state and the separation time, and
// drops all pending results.
// Depends on srr_pkg, srr_lane, srr_merge.
module segmented_response_reassembler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   byte0_i,
  input  logic [7:0]                   byte1_i,
  input  logic [7:0]                   byte2_i,
  input  logic [7:0]                   byte3_i,
  input  logic [7:0]                   byte4_i,
  input  logic [7:0]                   byte5_i,
  input  logic [7:0]                   byte6_i,
  input  logic [7:0]                   byte7_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [7:0]                   data_byte_o,
  output logic [srr_pkg::IdxW-1:0]     byte_index_o,
  output logic [15:0]                  data_ident_o,
  output logic                         last_of_run_o,
  output logic                         message_done_o
);

  localparam int unsigned IdxW = srr_pkg::IdxW;

  logic [7:0]      sep_q;
  logic            active_q, active_d;
  logic [IdxW-1:0] plen_q, plen_d;
  logic [IdxW-1:0] rcvd_q, rcvd_d;
  logic [3:0]      seq_q, seq_d;
  logic [15:0]     ident_q, ident_d;

  logic            ready, accept;
  logic [IdxW-1:0] total, plen_new;
  logic            is_first, is_consec;
  logic [IdxW:0]   rcvd_sum, plen_ext;
  logic            fc_valid;
  logic [IdxW-1:0] lane_plen;

  logic [7:0]                 lane_data [srr_pkg::NumLanes];
  logic [IdxW:0]              lane_idx  [srr_pkg::NumLanes];
  logic                       lane_en   [srr_pkg::NumLanes];
  srr_pkg::lane_res_t [srr_pkg::NumLanes-1:0] lane_res;

  assign accept     = in_valid_i && ready;
  assign in_stall_o = !ready;

  assign lane_data[0] = byte1_i;
  assign lane_data[1] = byte2_i;
  assign lane_data[2] = byte3_i;
  assign lane_data[3] = byte4_i;
  assign lane_data[4] = byte5_i;
  assign lane_data[5] = byte6_i;
  assign lane_data[6] = byte7_i;

  always_comb begin
    total    = {byte0_i[3:0], byte1_i};
    plen_new = (total > srr_pkg::HeaderBytes) ? total - srr_pkg::HeaderBytes : '0;
    is_first = (byte0_i[7:4] == srr_pkg::PciFirst) && (byte2_i == srr_pkg::PositiveCode)
               && (plen_new != '0);
    // consecutive frame counts only while active and in sequence
    is_consec = (byte0_i[7:4] == srr_pkg::PciConsec) && active_q
                && ((byte0_i[3:0] & srr_pkg::LowNibble) == 4'(seq_q + 4'd1));

    lane_plen = is_first ? plen_new : plen_q;
    for (int k = 0; k < srr_pkg::NumLanes; k++) begin
      if (is_first) begin
        lane_en[k]  = (k >= srr_pkg::FirstLane);
        lane_idx[k] = 13'(k - srr_pkg::FirstLane);
      end else begin
        lane_en[k]  = is_consec;
        lane_idx[k] = {1'b0, rcvd_q} + 13'(k);
      end
    end
    fc_valid = is_first && (plen_new > srr_pkg::HeaderBytes);

    active_d = active_q;
    plen_d   = plen_q;
    rcvd_d   = rcvd_q;
    seq_d    = seq_q;
    ident_d  = ident_q;
    rcvd_sum = {1'b0, rcvd_q} + 13'(srr_pkg::NumLanes);
    plen_ext = {1'b0, plen_q};
    if (accept && is_first) begin
      ident_d = {byte3_i, byte4_i};
      plen_d  = plen_new;
      seq_d   = '0;
      if (plen_new <= srr_pkg::HeaderBytes) begin
        active_d = 1'b0;
        rcvd_d   = plen_new;
      end else begin
        active_d = 1'b1;
        rcvd_d   = srr_pkg::HeaderBytes;
      end
    end else if (accept && is_consec) begin
      seq_d = 4'(seq_q + 4'd1);
      if (rcvd_sum >= plen_ext) begin
        rcvd_d   = plen_q;
        active_d = 1'b0;
      end else begin
        rcvd_d = rcvd_sum[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q    <= '0;
      active_q <= 1'b0;
      plen_q   <= '0;
      rcvd_q   <= '0;
      seq_q    <= '0;
      ident_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        sep_q <= cfg_wdata_i;
      end
      active_q <= active_d;
      plen_q   <= plen_d;
      rcvd_q   <= rcvd_d;
      seq_q    <= seq_d;
      ident_q  <= ident_d;
    end
  end

  for (genvar g = 0; g < srr_pkg::NumLanes; g++) begin : g_lane
    srr_lane u_lane (
      .en_i    (lane_en[g]),
      .data_i  (lane_data[g]),
      .index_i (lane_idx[g]),
      .plen_i  (lane_plen),
      .res_o   (lane_res[g])
    );
  end

  srr_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .lanes_i        (lane_res),
    .fc_valid_i     (fc_valid),
    .fc_data_i      (sep_q),
    .ident_i        (ident_d),
    .ready_o        (ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .data_ident_o   (data_ident_o),
    .last_of_run_o  (last_of_run_o),
    .message_done_o (message_done_o)
  );

  // a new frame only enters once the previous frame's last result leaves
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!out_valid_o || (last_of_run_o && !out_stall_i)))
    else $error("frame accepted while results pending");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && message_done_o) |-> (last_of_run_o && kind_o == srr_pkg::KindPayload))
    else $error("message done not on last payload result");

  a_fc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == srr_pkg::KindFlowCtl) |-> (last_of_run_o && byte_index_o == '0))
    else $error("flow-control request malformed");

  a_active_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rcvd_q < plen_q))
    else $error("active with no bytes outstanding");

endmodule
